// ----- hw/rtl/julian_day_to_calendar_date_defines.svh -----
// ----------------------------------------------------------------------------
// Julian day to calendar date: assertion macros
// Shared property wrappers used by the RTL of the date converter.
// ----------------------------------------------------------------------------
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define JDC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define JDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/jdc_pkg.sv -----
// ----------------------------------------------------------------------------
// jdc_pkg
// Types, constants and tables for the Julian day to calendar date converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

   // widths
   localparam int DAY_BITS_DEFAULT = 32;
   localparam int LEN_BITS         = 29;   // widest chunk length, 365242538
   localparam int DOM_BITS         = 5;
   localparam int MONTH_BITS       = 4;
   localparam int MAG_BITS         = 24;
   localparam int MOD_BITS         = 9;    // year mod 400

   // chunk lengths in days
   localparam int MEGA_LEN_FIRST   = 365242538;
   localparam int MEGA_LEN         = 365242500;
   localparam int MYRIAD_LEN_FIRST = 3652463;
   localparam int MYRIAD_LEN       = 3652425;
   localparam int CENT_LEN_JULIAN  = 36525;
   localparam int CENT_LEN_1488    = 36515;
   localparam int CENT_LEN_GREG    = 36524;
   localparam int YEAR_LEN_1582    = 355;
   localparam int YEAR_LEN_LEAP    = 366;
   localparam int YEAR_LEN_COMMON  = 365;
   localparam int OCT_1582_LEN     = 21;
   localparam int FEB_LEAP_LEN     = 29;

   // year numbers and steps
   localparam int YEAR_START       = -4713;
   localparam int YEAR_MEGA_JUMP   = 995288;
   localparam int YEAR_MYRIAD_JUMP = 5288;
   localparam int YEAR_CENT_JUMP   = 88;
   localparam int YEAR_LAST_BC_C   = -13;
   localparam int YEAR_LAST_BC     = -1;
   localparam int YEAR_FIRST_AD    = 1;
   localparam int YEAR_MEGA_STEP   = 1000000;
   localparam int YEAR_MYRIAD_STEP = 10000;
   localparam int YEAR_CENT_STEP   = 100;
   localparam int YEAR_REFORM      = 1582;
   localparam int YEAR_CENT_ODD    = 1488;

   // year mod 400 bookkeeping
   localparam int MOD_START        = 87;   // -4713 mod 400
   localparam int MOD_JUMP         = 88;
   localparam int MOD_LONG_CENT    = 388;  // (y - 88) mod 400 == 300
   localparam int MOD_LAST         = 399;

   // months
   localparam int MONTH_JAN        = 1;
   localparam int MONTH_FEB        = 2;
   localparam int MONTH_OCT        = 10;
   localparam int MONTH_DEC        = 12;
   localparam int OCT_GAP_START    = 4;
   localparam int OCT_GAP_DAYS     = 10;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_MEGA    = 6'b000010,
      ST_MYRIAD  = 6'b000100,
      ST_CENTURY = 6'b001000,
      ST_YEAR    = 6'b010000,
      ST_MONTH   = 6'b100000
   } state_type;

   // common-year month lengths
   function automatic logic [DOM_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] month);
      logic [DOM_BITS-1:0] len;
      unique case (month)
         4'd2:                   len = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:                len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ----- hw/rtl/jdc_len.sv -----
// ----------------------------------------------------------------------------
// jdc_len
// Calendar rules: length in days of the chunk the sequencer tries next.
// ----------------------------------------------------------------------------
module jdc_len import jdc_pkg::*; #(
   parameter int YEAR_BITS = DAY_BITS_DEFAULT
) (
   input  state_type                    phase,
   input  logic signed [YEAR_BITS-1:0]  year,
   input  logic [MOD_BITS-1:0]          year_mod400,
   input  logic [MONTH_BITS-1:0]        month,
   output logic [LEN_BITS-1:0]          step_len
);

   localparam logic signed [YEAR_BITS-1:0] Y_START  = YEAR_BITS'(YEAR_START);
   localparam logic signed [YEAR_BITS-1:0] Y_REFORM = YEAR_BITS'(YEAR_REFORM);
   localparam logic signed [YEAR_BITS-1:0] Y_ODD    = YEAR_BITS'(YEAR_CENT_ODD);

   logic is_start;
   logic is_reform;
   logic gregorian;
   logic cent_year;
   logic leap;

   // leap rule: Gregorian from the reform on, Julian before, BC shifted by one
   always_comb begin
      is_start  = (year == Y_START);
      is_reform = (year == Y_REFORM);
      gregorian = (year >= Y_REFORM);
      cent_year = (year_mod400 == MOD_BITS'(0))   || (year_mod400 == MOD_BITS'(100)) ||
                  (year_mod400 == MOD_BITS'(200)) || (year_mod400 == MOD_BITS'(300));
      if (gregorian) begin
         leap = (year_mod400 == MOD_BITS'(0)) || ((year[1:0] == 2'b00) && !cent_year);
      end else if (year[YEAR_BITS-1]) begin
         leap = (year[1:0] == 2'b11);
      end else begin
         leap = (year[1:0] == 2'b00);
      end
   end

   // chunk length per phase
   always_comb begin
      unique case (phase)
         ST_MEGA: begin
            step_len = is_start ? LEN_BITS'(MEGA_LEN_FIRST) : LEN_BITS'(MEGA_LEN);
         end
         ST_MYRIAD: begin
            step_len = is_start ? LEN_BITS'(MYRIAD_LEN_FIRST) : LEN_BITS'(MYRIAD_LEN);
         end
         ST_CENTURY: begin
            if (year < Y_ODD) begin
               step_len = LEN_BITS'(CENT_LEN_JULIAN);
            end else if (year == Y_ODD) begin
               step_len = LEN_BITS'(CENT_LEN_1488);
            end else if (year_mod400 == MOD_BITS'(MOD_LONG_CENT)) begin
               step_len = LEN_BITS'(CENT_LEN_JULIAN);
            end else begin
               step_len = LEN_BITS'(CENT_LEN_GREG);
            end
         end
         ST_YEAR: begin
            if (is_reform) begin
               step_len = LEN_BITS'(YEAR_LEN_1582);
            end else begin
               step_len = leap ? LEN_BITS'(YEAR_LEN_LEAP) : LEN_BITS'(YEAR_LEN_COMMON);
            end
         end
         ST_MONTH: begin
            if (is_reform && (month == MONTH_BITS'(MONTH_OCT))) begin
               step_len = LEN_BITS'(OCT_1582_LEN);
            end else if ((month == MONTH_BITS'(MONTH_FEB)) && leap) begin
               step_len = LEN_BITS'(FEB_LEAP_LEN);
            end else begin
               step_len = LEN_BITS'(month_len(month));
            end
         end
         default: begin
            step_len = '0;
         end
      endcase
   end

endmodule

// ----- hw/rtl/julian_day_to_calendar_date.sv -----
// Each word is taken in idle, then chunks are removed in order (megayears,
// ten-thousand-year blocks, centuries, years, months) before the result is registered.
// One compare-and-subtract unit tries one chunk per cycle unless a held result holds the sequencer.
// No new word is taken while one is in work,
// and a result held by rsp_stall holds the sequencer as well.
// Reset (synchronous, active high) clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// julian_day_to_calendar_date
// Converts a day count since 1 January 4713 BC into day, month, year and BC
// flag by repeated chunk subtraction through one shared subtractor.
// ----------------------------------------------------------------------------
`include "julian_day_to_calendar_date_defines.svh"

module julian_day_to_calendar_date import jdc_pkg::*; #(
   parameter int DAY_BITS = DAY_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [DAY_BITS-1:0]   req_day_number,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DOM_BITS-1:0]   rsp_day_of_month,
   output logic [MONTH_BITS-1:0] rsp_month_number,
   output logic [MAG_BITS-1:0]   rsp_year_magnitude,
   output logic                  rsp_before_christ
);

   localparam int YEAR_BITS = DAY_BITS;
   localparam int CMP_BITS  = ((DAY_BITS > LEN_BITS) ? DAY_BITS : LEN_BITS) + 1;

   localparam logic signed [YEAR_BITS-1:0] Y_START  = YEAR_BITS'(YEAR_START);
   localparam logic signed [YEAR_BITS-1:0] Y_LBC_C  = YEAR_BITS'(YEAR_LAST_BC_C);
   localparam logic signed [YEAR_BITS-1:0] Y_LBC    = YEAR_BITS'(YEAR_LAST_BC);
   localparam logic signed [YEAR_BITS-1:0] Y_REFORM = YEAR_BITS'(YEAR_REFORM);

   state_type                    state_ff, state_in;
   logic [DAY_BITS-1:0]          rem_ff, rem_in;
   logic signed [YEAR_BITS-1:0]  year_ff, year_in;
   logic [MOD_BITS-1:0]          mod_ff, mod_in;
   logic [MONTH_BITS-1:0]        month_ff, month_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DOM_BITS-1:0]          dom_ff, dom_in;
   logic [MONTH_BITS-1:0]        mon_ff, mon_in;
   logic [MAG_BITS-1:0]          mag_ff, mag_in;
   logic                         bc_ff, bc_in;

   logic [LEN_BITS-1:0]          step_len;
   logic [CMP_BITS-1:0]          diff;
   logic                         fits;
   logic                         is_start;
   logic signed [YEAR_BITS-1:0]  year_add;
   logic signed [YEAR_BITS-1:0]  year_sum;
   logic signed [YEAR_BITS-1:0]  year_abs;
   logic                         out_free;
   logic [DOM_BITS-1:0]          dom_calc;

   // calendar rules pick the chunk length
   jdc_len #(
      .YEAR_BITS   (YEAR_BITS)
   ) u_len (
      .phase       (state_ff),
      .year        (year_ff),
      .year_mod400 (mod_ff),
      .month       (month_ff),
      .step_len    (step_len)
   );

   // shared compare and subtract: borrow clear means the chunk fits
   assign diff = {{(CMP_BITS-DAY_BITS){1'b0}}, rem_ff} - {{(CMP_BITS-LEN_BITS){1'b0}}, step_len};
   assign fits = ~diff[CMP_BITS-1];

   // year step adder
   always_comb begin
      is_start = (year_ff == Y_START);
      unique case (state_ff)
         ST_MEGA:    year_add = YEAR_BITS'(YEAR_MEGA_STEP);
         ST_MYRIAD:  year_add = YEAR_BITS'(YEAR_MYRIAD_STEP);
         ST_CENTURY: year_add = YEAR_BITS'(YEAR_CENT_STEP);
         default:    year_add = YEAR_BITS'(1);
      endcase
      year_sum = year_ff + year_add;
   end

   // result fields from what is left
   always_comb begin
      year_abs = year_ff[YEAR_BITS-1] ? -year_ff : year_ff;
      dom_calc = rem_ff[DOM_BITS-1:0] + DOM_BITS'(1);
      if ((year_ff == Y_REFORM) && (month_ff == MONTH_BITS'(MONTH_OCT)) &&
          (rem_ff >= DAY_BITS'(OCT_GAP_START))) begin
         dom_calc = dom_calc + DOM_BITS'(OCT_GAP_DAYS);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      year_in      = year_ff;
      mod_in       = mod_ff;
      month_in     = month_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      dom_in       = dom_ff;
      mon_in       = mon_ff;
      mag_in       = mag_ff;
      bc_in        = bc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               rem_in   = req_day_number;
               year_in  = Y_START;
               mod_in   = MOD_BITS'(MOD_START);
               month_in = MONTH_BITS'(MONTH_JAN);
               state_in = ST_MEGA;
            end
         end
         ST_MEGA: begin
            if (fits) begin
               rem_in  = diff[DAY_BITS-1:0];
               year_in = is_start ? YEAR_BITS'(YEAR_MEGA_JUMP) : year_sum;
               mod_in  = is_start ? MOD_BITS'(MOD_JUMP) : mod_ff;
            end else begin
               state_in = ST_MYRIAD;
            end
         end
         ST_MYRIAD: begin
            if (fits) begin
               rem_in  = diff[DAY_BITS-1:0];
               year_in = is_start ? YEAR_BITS'(YEAR_MYRIAD_JUMP) : year_sum;
               mod_in  = is_start ? MOD_BITS'(MOD_JUMP) : mod_ff;
            end else begin
               state_in = ST_CENTURY;
            end
         end
         ST_CENTURY: begin
            if (fits) begin
               rem_in = diff[DAY_BITS-1:0];
               if (year_ff == Y_LBC_C) begin
                  year_in = YEAR_BITS'(YEAR_CENT_JUMP);
                  mod_in  = MOD_BITS'(MOD_JUMP);
               end else begin
                  year_in = year_sum;
                  mod_in  = (mod_ff >= MOD_BITS'(300)) ? mod_ff - MOD_BITS'(300)
                                                       : mod_ff + MOD_BITS'(100);
               end
            end else begin
               state_in = ST_YEAR;
            end
         end
         ST_YEAR: begin
            if (fits) begin
               rem_in = diff[DAY_BITS-1:0];
               if (year_ff == Y_LBC) begin
                  year_in = YEAR_BITS'(YEAR_FIRST_AD);
                  mod_in  = MOD_BITS'(YEAR_FIRST_AD);
               end else begin
                  year_in = year_sum;
                  mod_in  = (mod_ff == MOD_BITS'(MOD_LAST)) ? '0 : mod_ff + MOD_BITS'(1);
               end
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (fits && (month_ff != MONTH_BITS'(MONTH_DEC))) begin
               rem_in   = diff[DAY_BITS-1:0];
               month_in = month_ff + MONTH_BITS'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               dom_in       = dom_calc;
               mon_in       = month_ff;
               mag_in       = year_abs[MAG_BITS-1:0];
               bc_in        = year_ff[YEAR_BITS-1];
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath and result registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      year_ff  <= year_in;
      mod_ff   <= mod_in;
      month_ff <= month_in;
      dom_ff   <= dom_in;
      mon_ff   <= mon_in;
      mag_ff   <= mag_in;
      bc_ff    <= bc_in;
   end

   assign req_stall          = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_day_of_month   = dom_ff;
   assign rsp_month_number   = mon_ff;
   assign rsp_year_magnitude = mag_ff;
   assign rsp_before_christ  = bc_ff;

   // checks
   `JDC_ASSERT_SAME(a_month_range, clock, reset, state_ff == ST_MONTH,
      (month_ff >= MONTH_BITS'(MONTH_JAN)) && (month_ff <= MONTH_BITS'(MONTH_DEC)),
      "month out of range")
   `JDC_ASSERT_NEXT(a_rem_down, clock, reset, state_ff != ST_IDLE,
      rem_ff <= $past(rem_ff), "remaining days grew")
   `JDC_ASSERT_NEXT(a_year_up, clock, reset, state_ff != ST_IDLE,
      year_ff >= $past(year_ff), "year went back")

endmodule
